### src/psfm_pkg.sv
package psfm_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned PhaseW    = $clog2(FrameBits) + 1;
  localparam int unsigned GapW      = 12;
  localparam int unsigned CaptW     = 8;
  localparam logic [GapW-1:0] GapReset = GapW'(280);

  // Read frames send the frame twice, writes once
  localparam logic [1:0] FramesWrite = 2'd1;
  localparam logic [1:0] FramesRead  = 2'd2;

  // Config register byte offsets (word index in paddr[2])
  localparam logic RegGapTicks = 1'b0;

  // Input tuser codes
  localparam logic KindTick  = 1'b0;
  localparam logic KindStart = 1'b1;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_FRAME = 3'b010,
    SEQ_GAP   = 3'b100
  } seq_e;

  typedef struct packed {
    seq_e                  seq;
    logic [FrameBits-1:0]  frame;
    logic [PhaseW-1:0]     phase;
    logic                  clk_high;
    logic [1:0]            frames_left;
    logic [GapW-1:0]       gap_count;
    logic                  port;
    logic [CaptW-1:0]      capture;
  } seq_state_t;

  typedef struct packed {
    logic       kind;
    logic       port_select;
    logic       write_not_read;
    logic [3:0] reg_address;
    logic [7:0] write_data;
    logic       miso;
  } tick_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       mosi;
    logic       sck;
    logic       cs2_n;
    logic       cs1_n;
  } tick_out_t;

endpackage

### src/parity_spi_register_frame_master.sv
// Each accepted input word has its result word registered and offered in the next cycle.
// Throughput: one word per cycle while the output side drains results; the sequencer state register is the only loop.
// Reset: rst_ni is asynchronous, active low; sequencer goes idle with all
// state zero, gap_ticks returns to 280 and the output register empties.
// The result register decouples the sides, so input is taken while a result waits
// as long as m_axis_tready drains it in the same cycle.
module parity_spi_register_frame_master
  import psfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] port_select, [1] write_not_read, [5:2] reg_address,
  // [13:6] write_data, [14] miso, [15] zero
  input  logic [15:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] cs1_n, [1] cs2_n, [2] sck, [3] mosi, [4] busy_res, [5] done_res,
  // [13:6] read_byte, [15:14] zero
  output logic [15:0] m_axis_tdata
);

  logic            in_fire;
  logic [GapW-1:0] gap_ticks;
  tick_in_t        tick;
  seq_state_t      state_q, state_d;
  tick_out_t       res_d, res_q;
  logic            out_valid_q;

  psfm_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gap_ticks_o (gap_ticks)
  );

  // unpack input word
  assign tick.kind           = s_axis_tuser;
  assign tick.port_select    = s_axis_tdata[0];
  assign tick.write_not_read = s_axis_tdata[1];
  assign tick.reg_address    = s_axis_tdata[5:2];
  assign tick.write_data     = s_axis_tdata[13:6];
  assign tick.miso           = s_axis_tdata[14];

  psfm_step u_step (
    .cur_i       (state_q),
    .tick_i      (tick),
    .gap_ticks_i (gap_ticks),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{seq: SEQ_IDLE, default: '0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.read_byte, res_q.done_res, res_q.busy_res,
                          res_q.mosi, res_q.sck, res_q.cs2_n, res_q.cs1_n};

  // done word closes the transaction with both selects released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res && res_q.cs1_n && res_q.cs2_n)
    else $error("done word with busy or chip select active");

  // a clock pulse always has exactly one chip select low
  a_sck_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.sck |-> res_q.cs1_n != res_q.cs2_n)
    else $error("sck high without a single chip select");

  // bit counter never passes the frame end
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.seq == SEQ_FRAME |-> state_q.phase <= PhaseW'(FrameBits))
    else $error("bit phase beyond frame");

  // a start taken while idle enters the frame
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser && state_q.seq == SEQ_IDLE |=> state_q.seq == SEQ_FRAME)
    else $error("start not taken while idle");

endmodule

### src/psfm_apb.sv
module psfm_apb
  import psfm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [GapW-1:0] gap_ticks_o
);

  logic [GapW-1:0] gap_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegGapTicks);

  // gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GapReset;
    end else if (wr_en) begin
      gap_q <= pwdata[GapW-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegGapTicks) begin
      prdata = {{(32-GapW){1'b0}}, gap_q};
    end
  end

  assign gap_ticks_o = gap_q;

endmodule

### src/psfm_step.sv
module psfm_step
  import psfm_pkg::*;
(
  input  seq_state_t      cur_i,
  input  tick_in_t        tick_i,
  input  logic [GapW-1:0] gap_ticks_i,
  output seq_state_t      nxt_o,
  output tick_out_t       res_o
);

  logic       cs_low;
  logic       parity;
  logic [3:0] bit_idx;

  // frame bit index, MSB first
  assign bit_idx = 4'(FrameBits - 1) - cur_i.phase[3:0];
  // odd parity over write flag, address and data
  assign parity  = ~(^{tick_i.write_not_read, tick_i.reg_address, tick_i.write_data});

  always_comb begin
    nxt_o           = cur_i;
    cs_low          = 1'b0;
    res_o           = '0;
    case (cur_i.seq)
      SEQ_FRAME: begin
        res_o.busy_res = 1'b1;
        if (cur_i.phase < PhaseW'(FrameBits)) begin
          cs_low     = 1'b1;
          res_o.mosi = cur_i.frame[bit_idx];
          if (!cur_i.clk_high) begin
            res_o.sck      = 1'b1;
            nxt_o.capture  = {cur_i.capture[CaptW-2:0], tick_i.miso};
            nxt_o.clk_high = 1'b1;
          end else begin
            nxt_o.clk_high = 1'b0;
            nxt_o.phase    = cur_i.phase + PhaseW'(1);
          end
        end else if (cur_i.frames_left <= FramesWrite) begin
          nxt_o.frames_left = '0;
          res_o.busy_res    = 1'b0;
          res_o.done_res    = 1'b1;
          res_o.read_byte   = cur_i.capture;
          nxt_o.seq         = SEQ_IDLE;
        end else begin
          nxt_o.frames_left = cur_i.frames_left - 2'd1;
          nxt_o.gap_count   = gap_ticks_i;
          nxt_o.seq         = SEQ_GAP;
        end
      end
      SEQ_GAP: begin
        res_o.busy_res = 1'b1;
        if (cur_i.gap_count == '0) begin
          nxt_o.seq      = SEQ_FRAME;
          nxt_o.phase    = '0;
          nxt_o.clk_high = 1'b0;
          cs_low         = 1'b1;
        end else begin
          nxt_o.gap_count = cur_i.gap_count - GapW'(1);
        end
      end
      default: begin
        nxt_o.seq = SEQ_IDLE;
        if (tick_i.kind == KindStart) begin
          nxt_o.frame       = {tick_i.write_not_read, parity, 2'b00,
                               tick_i.reg_address, tick_i.write_data};
          nxt_o.port        = tick_i.port_select;
          nxt_o.frames_left = tick_i.write_not_read ? FramesWrite : FramesRead;
          nxt_o.phase       = '0;
          nxt_o.clk_high    = 1'b0;
          nxt_o.gap_count   = '0;
          nxt_o.seq         = SEQ_FRAME;
          res_o.busy_res    = 1'b1;
          cs_low            = 1'b1;
        end
      end
    endcase
    res_o.cs1_n = !(cs_low && nxt_o.port);
    res_o.cs2_n = !(cs_low && !nxt_o.port);
  end

endmodule

### bench/spi_pin_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the config port, predicts every output word of the
// SPI frame sequencer and compares it with what the block sends.
module spi_pin_checker
  import psfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          fail_count,
  output int          words_pending,
  output logic        sequencer_idle
);

  // Predicted sequencer state and its gap setting
  logic [GapW-1:0]      gap_ticks_q;
  seq_e                 seq_q;
  logic [FrameBits-1:0] frame_q;
  logic [PhaseW-1:0]    phase_q;
  logic                 clk_high_q;
  logic [1:0]           frames_left_q;
  logic [GapW-1:0]      gap_count_q;
  logic                 port_q;
  logic [CaptW-1:0]     capture_q;

  // Pin words predicted but not yet seen on the output stream
  tick_out_t pin_queue[$];

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    fail_count++;
    if (fail_count <= 20) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // One clock tick of the pin sequencer; returns the pin word it produces
  function automatic tick_out_t step_sequencer(input tick_in_t w);
    tick_out_t o;
    logic      cs_low;
    o      = '0;
    cs_low = 1'b0;
    case (seq_q)
      SEQ_FRAME: begin
        o.busy_res = 1'b1;
        if (phase_q < FrameBits) begin
          cs_low = 1'b1;
          o.mosi = frame_q[4'(FrameBits - 1) - phase_q[3:0]];
          if (!clk_high_q) begin
            // rise tick: sample miso
            o.sck      = 1'b1;
            capture_q  = {capture_q[CaptW-2:0], w.miso};
            clk_high_q = 1'b1;
          end else begin
            clk_high_q = 1'b0;
            phase_q    = phase_q + PhaseW'(1);
          end
        end else if (frames_left_q <= FramesWrite) begin
          // last frame done
          frames_left_q = '0;
          o.busy_res    = 1'b0;
          o.done_res    = 1'b1;
          o.read_byte   = capture_q;
          seq_q         = SEQ_IDLE;
        end else begin
          frames_left_q = frames_left_q - 2'd1;
          gap_count_q   = gap_ticks_q;
          seq_q         = SEQ_GAP;
        end
      end
      SEQ_GAP: begin
        o.busy_res = 1'b1;
        if (gap_count_q == '0) begin
          // setup tick of the repeated frame
          seq_q      = SEQ_FRAME;
          phase_q    = '0;
          clk_high_q = 1'b0;
          cs_low     = 1'b1;
        end else begin
          gap_count_q = gap_count_q - GapW'(1);
        end
      end
      default: begin
        seq_q = SEQ_IDLE;
        if (w.kind == KindStart) begin
          // odd parity over write flag, address and data
          frame_q = {w.write_not_read, ~^{w.write_not_read, w.reg_address, w.write_data},
                     2'b00, w.reg_address, w.write_data};
          port_q        = w.port_select;
          frames_left_q = w.write_not_read ? FramesWrite : FramesRead;
          phase_q       = '0;
          clk_high_q    = 1'b0;
          gap_count_q   = '0;
          seq_q         = SEQ_FRAME;
          o.busy_res    = 1'b1;
          cs_low        = 1'b1;
        end
      end
    endcase
    o.cs1_n = !(cs_low && port_q);
    o.cs2_n = !(cs_low && !port_q);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_in_t  w;
    tick_out_t got;
    tick_out_t want;
    if (!rst_ni) begin
      gap_ticks_q   = GapReset;
      seq_q         = SEQ_IDLE;
      frame_q       = '0;
      phase_q       = '0;
      clk_high_q    = 1'b0;
      frames_left_q = '0;
      gap_count_q   = '0;
      port_q        = 1'b0;
      capture_q     = '0;
      fail_count    = 0;
      pin_queue.delete();
    end else begin
      // output word against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.cs1_n     = m_axis_tdata[0];
        got.cs2_n     = m_axis_tdata[1];
        got.sck       = m_axis_tdata[2];
        got.mosi      = m_axis_tdata[3];
        got.busy_res  = m_axis_tdata[4];
        got.done_res  = m_axis_tdata[5];
        got.read_byte = m_axis_tdata[13:6];
        if (pin_queue.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata[7:0], 8'h00);
        end else begin
          want = pin_queue.pop_front();
          if (got.cs1_n !== want.cs1_n) begin
            report_mismatch("cs1_n", 8'(got.cs1_n), 8'(want.cs1_n));
          end
          if (got.cs2_n !== want.cs2_n) begin
            report_mismatch("cs2_n", 8'(got.cs2_n), 8'(want.cs2_n));
          end
          if (got.sck !== want.sck) begin
            report_mismatch("sck", 8'(got.sck), 8'(want.sck));
          end
          if (got.mosi !== want.mosi) begin
            report_mismatch("mosi", 8'(got.mosi), 8'(want.mosi));
          end
          if (got.busy_res !== want.busy_res) begin
            report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          end
          if (got.done_res !== want.done_res) begin
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          end
          if (got.read_byte !== want.read_byte) begin
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          end
          if (m_axis_tdata[15:14] !== 2'b00) begin
            report_mismatch("pad bits", 8'(m_axis_tdata[15:14]), 8'h00);
          end
        end
      end
      // input word: predict its pin word
      if (s_axis_tvalid && s_axis_tready) begin
        w.kind           = s_axis_tuser;
        w.port_select    = s_axis_tdata[0];
        w.write_not_read = s_axis_tdata[1];
        w.reg_address    = s_axis_tdata[5:2];
        w.write_data     = s_axis_tdata[13:6];
        w.miso           = s_axis_tdata[14];
        pin_queue.push_back(step_sequencer(w));
      end
      // config write takes effect for the words after this edge
      if (psel && penable && pwrite && pready && paddr == {RegGapTicks, 2'b00}) begin
        gap_ticks_q = pwdata[GapW-1:0];
      end
    end
    words_pending  = pin_queue.size();
    sequencer_idle = (seq_q == SEQ_IDLE);
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb
  import psfm_pkg::*;
;

  localparam int LongHold = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [0] port_select, [1] write_not_read, [5:2] reg_address,
  // [13:6] write_data, [14] miso, [15] zero
  logic [15:0] s_axis_tdata;
  // [0] kind
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] cs1_n, [1] cs2_n, [2] sck, [3] mosi, [4] busy_res, [5] done_res,
  // [13:6] read_byte, [15:14] zero
  logic [15:0] m_axis_tdata;

  int   fail_count;
  int   words_pending;
  logic sequencer_idle;
  int   hold_requests = 0;
  int   burst_left = 0;

  parity_spi_register_frame_master DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  spi_pin_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .fail_count     (fail_count),
    .words_pending  (words_pending),
    .sequencer_idle (sequencer_idle)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("FAIL parity_spi_register_frame_master");
    $finish;
  end

  // Output side: stall modes that change every so often, plus long hold-offs on request
  initial begin : sink
    int mode;
    int span;
    int beat;
    int hold_served;
    m_axis_tready = 1'b0;
    mode          = 0;
    span          = 0;
    beat          = 0;
    hold_served   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served < hold_requests) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 200);
        end
        span--;
        beat++;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (beat % 5 != 0);
        endcase
      end
    end
  end

  function automatic tick_in_t random_word(input logic kind);
    tick_in_t w;
    w.kind           = kind;
    w.port_select    = 1'($urandom_range(0, 1));
    w.write_not_read = 1'($urandom_range(0, 1));
    w.reg_address    = 4'($urandom_range(0, 15));
    w.write_data     = 8'($urandom_range(0, 255));
    w.miso           = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offer one word in bursts with random gaps; returns at the falling edge after it is taken
  task automatic offer_word(input tick_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, w.miso, w.write_data, w.reg_address, w.write_not_read,
                      w.port_select};
    s_axis_tuser  <= w.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Tick the sequencer back to idle, then wait for every pin word
  task automatic finish_phase();
    while (!sequencer_idle) offer_word(random_word(KindTick));
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_gap(input logic [GapW-1:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegGapTicks, 2'b00};
    pwdata  <= 32'(ticks);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // One whole transaction; busy_starts also raises kind on every tick while busy
  task automatic run_frame(input logic port, input logic wnr, input logic [3:0] addr,
                           input logic [7:0] data, input logic busy_starts);
    tick_in_t w;
    w                = random_word(KindStart);
    w.port_select    = port;
    w.write_not_read = wnr;
    w.reg_address    = addr;
    w.write_data     = data;
    offer_word(w);
    while (!sequencer_idle) offer_word(random_word(busy_starts ? KindStart : KindTick));
  endtask

  initial begin : stimulus
    logic [GapW-1:0] gap_plan [5];
    int              item_plan[5];
    logic            start;
    gap_plan      = '{12'd1, 12'd280, 12'd2, 12'd0, 12'd5};
    item_plan     = '{300, 200, 300, 300, 250};
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KindTick;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero gap, field extremes, starts while busy and on the done tick
    write_gap(12'd0);
    run_frame(1'b1, 1'b1, 4'hf, 8'hff, 1'b0);
    run_frame(1'b0, 1'b0, 4'h0, 8'h00, 1'b1);
    run_frame(1'b0, 1'b1, 4'h0, 8'h00, 1'b0);
    run_frame(1'b1, 1'b0, 4'hf, 8'hff, 1'b0);
    run_frame(1'b1, 1'b1, 4'ha, 8'h55, 1'b1);
    finish_phase();

    // Random phases, one gap setting each
    for (int p = 0; p < 5; p++) begin
      write_gap(gap_plan[p]);
      for (int i = 0; i < item_plan[p]; i++) begin
        if (p == 0 && i == 150) begin
          // let the output side drain completely mid-phase
          s_axis_tvalid <= 1'b0;
          do @(negedge clk_i); while (words_pending != 0);
        end
        if (p == 2 && i == 100) hold_requests++;
        // mostly start when idle; occasional ignored starts while busy
        if (sequencer_idle) start = ($urandom_range(0, 3) != 0);
        else start = ($urandom_range(0, 9) == 0);
        offer_word(random_word(start ? KindStart : KindTick));
      end
      finish_phase();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS parity_spi_register_frame_master");
    end else begin
      $display("FAIL parity_spi_register_frame_master");
    end
    $finish;
  end

endmodule

### files.f
src/psfm_pkg.sv
src/psfm_apb.sv
src/psfm_step.sv
src/parity_spi_register_frame_master.sv
bench/spi_pin_checker.sv
bench/tb.sv
